// ===== hw/rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent basis package
// Shared constants, field widths and sequencer state codes.
// ----------------------------------------------------------------------------
package ttb_pkg;

    // Default parameter values.
    localparam int INDEX_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Significant bits of the largest component after normalizing.
    localparam int NORM_BITS = 30;

    // Fixed field widths.
    localparam int IDX_W   = 16;
    localparam int COORD_W = 32;
    localparam int DELTA_W = 33;
    localparam int PROD_W  = 66;
    localparam int VEC_W   = 67;
    localparam int MAG_W   = 66;
    localparam int UNIT_W  = 18;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MULT   = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_NORM   = 8'b0000_1000,
        ST_SQUARE = 8'b0001_0000,
        ST_SQRT   = 8'b0010_0000,
        ST_DLOAD  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

endpackage

// ===== hw/rtl/triangle_tangent_basis.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent basis
// Collects three corners and computes a unit tangent and bitangent per triangle
// with one shared multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
// The first two corners are taken one per cycle. The third corner starts the multiply
// and check steps, then per vector the normalize, square, square root and divide
// steps (skipped if degenerate), before three results, one per cycle while m_tready
// is high. No new corner is taken until the last result is sent.
// Throughput is bound by the shared divider and square root loop.
// Reset (aresetn low, synchronous) clears the sequencer and the corner count.
module triangle_tangent_basis
    import ttb_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // vertex_index[15:0], pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each)
    input  logic [175:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // corner_index[15:0], tangent_x/y/z, bitangent_x/y/z (18 bits each), 4 zero bits
    output logic [127:0] m_tdata,
    // degenerate
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int IW  = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
    localparam int NW  = NORM_BITS + FRAC_BITS + 1;
    localparam int DCW = $clog2(NW + 1);

    state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [IW-1:0] hidx_reg [2], hidx_next [2];
    logic [IW-1:0] idx2_reg, idx2_next;
    logic signed [COORD_W-1:0] hpos_reg [2][3], hpos_next [2][3];
    logic signed [COORD_W-1:0] htex_reg [2][2], htex_next [2][2];

    logic signed [DELTA_W-1:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [DELTA_W-1:0] d1u_next, d1v_next, d2u_next, d2v_next;
    logic signed [DELTA_W-1:0] e1_reg [3], e1_next [3], e2_reg [3], e2_next [3];

    logic [3:0] ps_reg, ps_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [VEC_W-1:0] vec_reg [7], vec_next [7];

    logic vsel_reg, vsel_next;
    logic [MAG_W-1:0] mag_reg [3], mag_next [3];
    logic neg_reg [3], neg_next [3];
    logic [63:0] sum_reg, sum_next;
    logic [1:0] sqc_reg, sqc_next;
    logic [63:0] n_reg, n_next, r_reg, r_next, b_reg, b_next;
    logic [31:0] l_reg, l_next;
    logic [1:0] cc_reg, cc_next;
    logic [NW-1:0] num_reg, num_next;
    logic [31:0] rem_reg, rem_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic signed [UNIT_W-1:0] tan_reg [3], tan_next [3], btan_reg [3], btan_next [3];
    logic degen_reg, degen_next;
    logic [1:0] oc_reg, oc_next;

    // Input fields.
    logic [IDX_W-1:0] in_idx;
    logic signed [COORD_W-1:0] in_pos [3];
    logic signed [COORD_W-1:0] in_tex [2];
    logic s_fire, m_fire;

    assign in_idx    = s_tdata[15:0];
    assign in_pos[0] = s_tdata[47:16];
    assign in_pos[1] = s_tdata[79:48];
    assign in_pos[2] = s_tdata[111:80];
    assign in_tex[0] = s_tdata[143:112];
    assign in_tex[1] = s_tdata[175:144];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_fire   = m_tvalid && m_tready;

    // Shared multiplier operand selection.
    logic signed [DELTA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [MAG_W-1:0] sq_m;

    always_comb begin
        unique case (sqc_reg)
            2'd0:    sq_m = mag_reg[0];
            2'd1:    sq_m = mag_reg[1];
            default: sq_m = mag_reg[2];
        endcase
    end

    always_comb begin
        mul_a = d1u_reg;
        mul_b = d2v_reg;
        if (state_reg == ST_SQUARE) begin
            mul_a = DELTA_W'(sq_m[NORM_BITS-1:0]);
            mul_b = DELTA_W'(sq_m[NORM_BITS-1:0]);
        end else begin
            unique case (ps_reg)
                4'd0:  begin mul_a = d1u_reg; mul_b = d2v_reg;  end
                4'd1:  begin mul_a = d1v_reg; mul_b = d2u_reg;  end
                4'd2:  begin mul_a = d2v_reg; mul_b = e1_reg[0]; end
                4'd3:  begin mul_a = d1v_reg; mul_b = e2_reg[0]; end
                4'd4:  begin mul_a = d2v_reg; mul_b = e1_reg[1]; end
                4'd5:  begin mul_a = d1v_reg; mul_b = e2_reg[1]; end
                4'd6:  begin mul_a = d2v_reg; mul_b = e1_reg[2]; end
                4'd7:  begin mul_a = d1v_reg; mul_b = e2_reg[2]; end
                4'd8:  begin mul_a = d1u_reg; mul_b = e2_reg[0]; end
                4'd9:  begin mul_a = d2u_reg; mul_b = e1_reg[0]; end
                4'd10: begin mul_a = d1u_reg; mul_b = e2_reg[1]; end
                4'd11: begin mul_a = d2u_reg; mul_b = e1_reg[1]; end
                4'd12: begin mul_a = d1u_reg; mul_b = e2_reg[2]; end
                4'd13: begin mul_a = d2u_reg; mul_b = e1_reg[2]; end
                default: begin mul_a = d1u_reg; mul_b = d2v_reg; end
            endcase
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Helpers for the sequencer.
    logic [MAG_W-1:0] mag_or;
    logic [63:0] sq_trial;
    logic [32:0] div_trial;
    logic [NW-1:0] div_m;
    logic [UNIT_W-1:0] q_mag;
    logic signed [UNIT_W-1:0] q_signed;
    logic q_neg;
    logic [MAG_W-1:0] vmag [3];
    logic vneg [3];
    logic tan_zero, btan_zero;

    assign mag_or    = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign sq_trial  = r_reg + b_reg;
    assign div_trial = {rem_reg, num_reg[NW-1]};
    assign tan_zero  = (vec_reg[1] == '0) && (vec_reg[2] == '0) && (vec_reg[3] == '0);
    assign btan_zero = (vec_reg[4] == '0) && (vec_reg[5] == '0) && (vec_reg[6] == '0);

    always_comb begin
        unique case (cc_reg)
            2'd0:    begin div_m = NW'(mag_reg[0][NORM_BITS-1:0]); q_neg = neg_reg[0]; end
            2'd1:    begin div_m = NW'(mag_reg[1][NORM_BITS-1:0]); q_neg = neg_reg[1]; end
            default: begin div_m = NW'(mag_reg[2][NORM_BITS-1:0]); q_neg = neg_reg[2]; end
        endcase
    end

    assign q_mag    = num_reg[UNIT_W-1:0];
    assign q_signed = q_neg ? UNIT_W'(18'd0 - q_mag) : q_mag;

    // Magnitudes and signs of the tangent, normalized first.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic signed [VEC_W-1:0] v;
            logic [VEC_W-1:0] a;
            v = vec_reg[1 + j];
            a = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
            vmag[j] = a[MAG_W-1:0];
            vneg[j] = v[VEC_W-1] ^ vec_reg[0][VEC_W-1];
        end
    end

    // A quotient is complete when the divide count ran down since the last load.
    logic done_flag_reg, done_flag_next;
    logic [MAG_W-1:0] vmag_b [3];
    logic vneg_b [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [VEC_W-1:0] a;
            a = vec_reg[4 + j][VEC_W-1] ? VEC_W'(-vec_reg[4 + j]) : VEC_W'(vec_reg[4 + j]);
            vmag_b[j] = a[MAG_W-1:0];
            vneg_b[j] = vec_reg[4 + j][VEC_W-1] ^ vec_reg[0][VEC_W-1];
        end
    end

    always_comb begin
        done_flag_next = done_flag_reg;
        if (state_reg == ST_DLOAD) begin
            if (dcnt_reg == DCW'(1)) begin
                done_flag_next = 1'b1;
            end else if (dcnt_reg == '0) begin
                done_flag_next = 1'b0;
            end
        end else begin
            done_flag_next = 1'b0;
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hidx_next  = hidx_reg;
        idx2_next  = idx2_reg;
        hpos_next  = hpos_reg;
        htex_next  = htex_reg;
        d1u_next   = d1u_reg;
        d1v_next   = d1v_reg;
        d2u_next   = d2u_reg;
        d2v_next   = d2v_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        ps_next    = ps_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        vec_next   = vec_reg;
        vsel_next  = vsel_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        sum_next   = sum_reg;
        sqc_next   = sqc_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        l_next     = l_reg;
        cc_next    = cc_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        tan_next   = tan_reg;
        btan_next  = btan_reg;
        degen_next = degen_reg;
        oc_next    = oc_reg;

        unique case (state_reg)
            // Hold the first two corners; the third one starts the computation.
            ST_IDLE: begin
                if (s_fire) begin
                    if (cnt_reg == 2'd0 || cnt_reg == 2'd1) begin
                        hidx_next[cnt_reg[0]] = IW'(in_idx);
                        for (int j = 0; j < 3; j++) begin
                            hpos_next[cnt_reg[0]][j] = in_pos[j];
                        end
                        htex_next[cnt_reg[0]][0] = in_tex[0];
                        htex_next[cnt_reg[0]][1] = in_tex[1];
                        cnt_next = cnt_reg + 2'd1;
                    end else begin
                        idx2_next = IW'(in_idx);
                        for (int j = 0; j < 3; j++) begin
                            e1_next[j] = DELTA_W'(hpos_reg[1][j]) - DELTA_W'(hpos_reg[0][j]);
                            e2_next[j] = DELTA_W'(in_pos[j]) - DELTA_W'(hpos_reg[0][j]);
                        end
                        d1u_next   = DELTA_W'(htex_reg[1][0]) - DELTA_W'(htex_reg[0][0]);
                        d1v_next   = DELTA_W'(htex_reg[1][1]) - DELTA_W'(htex_reg[0][1]);
                        d2u_next   = DELTA_W'(in_tex[0]) - DELTA_W'(htex_reg[0][0]);
                        d2v_next   = DELTA_W'(in_tex[1]) - DELTA_W'(htex_reg[0][1]);
                        cnt_next   = 2'd0;
                        ps_next    = 4'd0;
                        state_next = ST_MULT;
                    end
                end
            end

            // Products in pairs: the second of each pair is subtracted from the first.
            ST_MULT: begin
                prod_next = mul_p;
                if (ps_reg != 4'd0) begin
                    if (!ps_reg[0]) begin
                        vec_next[3'(ps_reg[3:1] - 3'd1)] =
                            VEC_W'(acc_reg) - VEC_W'(prod_reg);
                    end else begin
                        acc_next = prod_reg;
                    end
                end
                if (ps_reg == 4'd14) begin
                    state_next = ST_CHECK;
                end
                ps_next = ps_reg + 4'd1;
            end

            // Zero determinant or a zero vector gives a degenerate triangle.
            ST_CHECK: begin
                if (vec_reg[0] == '0 || tan_zero || btan_zero) begin
                    degen_next = 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        tan_next[j]  = '0;
                        btan_next[j] = '0;
                    end
                    oc_next    = 2'd0;
                    state_next = ST_EMIT;
                end else begin
                    degen_next = 1'b0;
                    vsel_next  = 1'b0;
                    mag_next   = vmag;
                    neg_next   = vneg;
                    state_next = ST_NORM;
                end
            end

            // Shift all three magnitudes together until the largest has NORM_BITS bits.
            ST_NORM: begin
                if (mag_or[MAG_W-1:NORM_BITS] != '0) begin
                    for (int j = 0; j < 3; j++) begin
                        mag_next[j] = mag_reg[j] >> 1;
                    end
                end else if (!mag_or[NORM_BITS-1]) begin
                    for (int j = 0; j < 3; j++) begin
                        mag_next[j] = mag_reg[j] << 1;
                    end
                end else begin
                    sqc_next   = 2'd0;
                    sum_next   = '0;
                    state_next = ST_SQUARE;
                end
            end

            // Sum of squares through the shared multiplier.
            ST_SQUARE: begin
                prod_next = mul_p;
                if (sqc_reg != 2'd0) begin
                    sum_next = sum_reg + prod_reg[63:0];
                end
                if (sqc_reg == 2'd3) begin
                    n_next     = sum_reg + prod_reg[63:0];
                    r_next     = '0;
                    b_next     = 64'h4000_0000_0000_0000;
                    state_next = ST_SQRT;
                end
                sqc_next = sqc_reg + 2'd1;
            end

            // Integer square root, two bits of the radicand a step.
            ST_SQRT: begin
                if (b_reg == '0) begin
                    l_next     = r_reg[31:0];
                    cc_next    = 2'd0;
                    dcnt_next  = '0;
                    state_next = ST_DLOAD;
                end else begin
                    if (n_reg >= sq_trial) begin
                        n_next = n_reg - sq_trial;
                        r_next = (r_reg >> 1) + b_reg;
                    end else begin
                        r_next = r_reg >> 1;
                    end
                    b_next = b_reg >> 2;
                end
            end

            // Rounded quotient of one component, one quotient bit a cycle.
            ST_DLOAD: begin
                if (dcnt_reg != '0) begin
                    if (div_trial >= {1'b0, l_reg}) begin
                        rem_next = 32'(div_trial - {1'b0, l_reg});
                        num_next = {num_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_next = div_trial[31:0];
                        num_next = {num_reg[NW-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg - DCW'(1);
                end else if (!done_flag_reg) begin
                    num_next  = (div_m << FRAC_BITS) + NW'(l_reg >> 1);
                    rem_next  = '0;
                    dcnt_next = DCW'(NW);
                end
            end

            // Three results, one per corner.
            ST_EMIT: begin
                if (m_fire) begin
                    oc_next = oc_reg + 2'd1;
                    if (oc_reg == 2'd2) begin
                        oc_next    = 2'd0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Divider completion: store the component and move on.
        if (state_reg == ST_DLOAD && dcnt_reg == '0 && done_flag_reg) begin
            if (vsel_reg) begin
                btan_next[cc_reg] = q_signed;
            end else begin
                tan_next[cc_reg] = q_signed;
            end
            if (cc_reg == 2'd2) begin
                if (vsel_reg) begin
                    oc_next    = 2'd0;
                    state_next = ST_EMIT;
                end else begin
                    vsel_next  = 1'b1;
                    state_next = ST_NORM;
                    for (int j = 0; j < 3; j++) begin
                        mag_next[j] = vmag_b[j];
                        neg_next[j] = vneg_b[j];
                    end
                end
                cc_next = 2'd0;
            end else begin
                cc_next = cc_reg + 2'd1;
            end
        end
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            done_flag_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_flag_reg <= done_flag_next;
        end
        hidx_reg  <= hidx_next;
        idx2_reg  <= idx2_next;
        hpos_reg  <= hpos_next;
        htex_reg  <= htex_next;
        d1u_reg   <= d1u_next;
        d1v_reg   <= d1v_next;
        d2u_reg   <= d2u_next;
        d2v_reg   <= d2v_next;
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        ps_reg    <= ps_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        vec_reg   <= vec_next;
        vsel_reg  <= vsel_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        sum_reg   <= sum_next;
        sqc_reg   <= sqc_next;
        n_reg     <= n_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        l_reg     <= l_next;
        cc_reg    <= cc_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        tan_reg   <= tan_next;
        btan_reg  <= btan_next;
        degen_reg <= degen_next;
        oc_reg    <= oc_next;
    end

    // Result fields.
    logic [IW-1:0] out_idx;

    always_comb begin
        unique case (oc_reg)
            2'd0:    out_idx = hidx_reg[0];
            2'd1:    out_idx = hidx_reg[1];
            default: out_idx = idx2_reg;
        endcase
    end

    assign m_tdata = {4'b0000,
                      btan_reg[2], btan_reg[1], btan_reg[0],
                      tan_reg[2], tan_reg[1], tan_reg[0],
                      IDX_W'(out_idx)};
    assign m_tuser = degen_reg;
    assign m_tlast = (oc_reg == 2'd2);

endmodule

// ===== dv/triangle_tangent_basis_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent basis testbench
// Streams triangle corners into the block, predicts the unit tangent and
// bitangent of each triangle in exact fixed point, and checks every result
// against the oldest prediction while both sides idle at random in most tests.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_tb;
    import ttb_pkg::*;

    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int LIMIT   = 2000000;
    localparam int HOLD_CY = 3000;

    typedef struct packed {
        logic [15:0] corner_index;
        logic [17:0] tx, ty, tz, bx, by, bz;
        logic        degenerate;
        logic        last_of_triangle;
    } basis_t;

    typedef struct {
        logic        neg;
        logic [65:0] mag;
    } sm_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [175:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    basis_t      expected_basis[$];
    int          failures = 0;
    int          cycles = 0;
    int          sender_idle_pct = 35;
    bit          hold_receiver = 1'b0;
    bit          receiver_free = 1'b0;

    // Predictor state: corners of the open triangle.
    logic [1:0]  pred_count = 2'd0;
    logic [31:0] pred_pos[6];
    logic [31:0] pred_tex[4];
    logic [15:0] pred_idx[2];

    triangle_tangent_basis u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always #5 aclk = ~aclk;

    // Cycle counter with timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("triangle_tangent_basis_tb: FAIL");
            $finish;
        end
    end

    function automatic sm_t smul(longint a, longint b);
        sm_t r;
        logic [32:0] ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r.mag = 66'(ma) * 66'(mb);
        r.neg = (r.mag != 0) && ((a < 0) != (b < 0));
        return r;
    endfunction

    function automatic sm_t ssub(sm_t x, sm_t y);
        sm_t r;
        y.neg = (y.mag != 0) ? ~y.neg : 1'b0;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic int bit_len(logic [65:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 66; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a vector to unit length; returns 0 for a zero vector.
    function automatic bit unit_vector(sm_t v[3], logic flip, output logic [17:0] u[3]);
        int          maxl;
        logic [63:0] m[3], s, l, q;
        maxl = 0;
        s = 0;
        for (int i = 0; i < 3; i++) if (bit_len(v[i].mag) > maxl) maxl = bit_len(v[i].mag);
        if (maxl == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (maxl > NORM_BITS) m[i] = 64'(v[i].mag >> (maxl - NORM_BITS));
            else m[i] = 64'(v[i].mag << (NORM_BITS - maxl));
            s += m[i] * m[i];
        end
        l = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (l >> 1)) / l;
            u[i] = (v[i].neg != flip) ? 18'(-q) : 18'(q);
        end
        return 1'b1;
    endfunction

    // Updates the predictor with one accepted corner.
    task automatic predict_corner(logic [175:0] d);
        longint      p[3][3], t[3][2], e1[3], e2[3], d1u, d1v, d2u, d2v;
        sm_t         det, tv[3], bv[3];
        logic [17:0] tu[3], bu[3];
        logic        degen;
        basis_t      b;
        logic [15:0] corner_ids[3];
        if (pred_count < 2) begin
            for (int j = 0; j < 3; j++) pred_pos[pred_count*3+j] = d[16+32*j +: 32];
            pred_tex[pred_count*2]   = d[112 +: 32];
            pred_tex[pred_count*2+1] = d[144 +: 32];
            pred_idx[pred_count]     = d[15:0];
            pred_count++;
            return;
        end
        pred_count = 0;
        for (int c = 0; c < 2; c++) begin
            for (int j = 0; j < 3; j++) p[c][j] = longint'(signed'(pred_pos[c*3+j]));
            t[c][0] = longint'(signed'(pred_tex[c*2]));
            t[c][1] = longint'(signed'(pred_tex[c*2+1]));
        end
        for (int j = 0; j < 3; j++) p[2][j] = longint'(signed'(d[16+32*j +: 32]));
        t[2][0] = longint'(signed'(d[112 +: 32]));
        t[2][1] = longint'(signed'(d[144 +: 32]));
        for (int j = 0; j < 3; j++) begin
            e1[j] = p[1][j] - p[0][j];
            e2[j] = p[2][j] - p[0][j];
        end
        d1u = t[1][0] - t[0][0];
        d1v = t[1][1] - t[0][1];
        d2u = t[2][0] - t[0][0];
        d2v = t[2][1] - t[0][1];
        det = ssub(smul(d1u, d2v), smul(d1v, d2u));
        degen = 1'b0;
        tu = '{default: '0};
        bu = '{default: '0};
        if (det.mag == 0) begin
            degen = 1'b1;
        end else begin
            for (int j = 0; j < 3; j++) begin
                tv[j] = ssub(smul(d2v, e1[j]), smul(d1v, e2[j]));
                bv[j] = ssub(smul(d1u, e2[j]), smul(d2u, e1[j]));
            end
            if (!unit_vector(tv, det.neg, tu) || !unit_vector(bv, det.neg, bu)) begin
                degen = 1'b1;
                tu = '{default: '0};
                bu = '{default: '0};
            end
        end
        corner_ids = '{pred_idx[0], pred_idx[1], d[15:0]};
        for (int k = 0; k < 3; k++) begin
            b.corner_index = corner_ids[k];
            b.tx = tu[0]; b.ty = tu[1]; b.tz = tu[2];
            b.bx = bu[0]; b.by = bu[1]; b.bz = bu[2];
            b.degenerate = degen;
            b.last_of_triangle = (k == 2);
            expected_basis.push_back(b);
        end
    endtask

    // Sends one corner, with a random gap before it.
    task automatic send_corner(logic [15:0] idx, logic [31:0] px, logic [31:0] py,
                               logic [31:0] pz, logic [31:0] tu, logic [31:0] tv);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {tv, tu, pz, py, px, idx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_corner({tv, tu, pz, py, px, idx});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8192)) - 4096) << 12;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return 32'($signed($urandom_range(6)) - 3) << 16;
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_basis.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // Receiver: random ready, or held off on request.
    always @(posedge aclk) begin
        if (hold_receiver) m_tready <= 1'b0;
        else if (receiver_free) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 35);
    end

    // Result checker.
    always @(posedge aclk) begin
        basis_t got, exp_b;
        if (aresetn && m_tvalid && m_tready) begin
            got.corner_index = m_tdata[15:0];
            got.tx = m_tdata[16 +: 18]; got.ty = m_tdata[34 +: 18];
            got.tz = m_tdata[52 +: 18]; got.bx = m_tdata[70 +: 18];
            got.by = m_tdata[88 +: 18]; got.bz = m_tdata[106 +: 18];
            got.degenerate = m_tuser[0];
            got.last_of_triangle = m_tlast;
            if (expected_basis.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                failures++;
            end else begin
                exp_b = expected_basis.pop_front();
                if (got.corner_index != exp_b.corner_index) begin
                    $error("corner_index exp %h got %h", exp_b.corner_index, got.corner_index);
                    failures++;
                end
                if (got.tx != exp_b.tx) begin
                    $error("tangent_x exp %h got %h", exp_b.tx, got.tx); failures++;
                end
                if (got.ty != exp_b.ty) begin
                    $error("tangent_y exp %h got %h", exp_b.ty, got.ty); failures++;
                end
                if (got.tz != exp_b.tz) begin
                    $error("tangent_z exp %h got %h", exp_b.tz, got.tz); failures++;
                end
                if (got.bx != exp_b.bx) begin
                    $error("bitangent_x exp %h got %h", exp_b.bx, got.bx); failures++;
                end
                if (got.by != exp_b.by) begin
                    $error("bitangent_y exp %h got %h", exp_b.by, got.by); failures++;
                end
                if (got.bz != exp_b.bz) begin
                    $error("bitangent_z exp %h got %h", exp_b.bz, got.bz); failures++;
                end
                if (got.degenerate != exp_b.degenerate) begin
                    $error("degenerate exp %b got %b", exp_b.degenerate, got.degenerate);
                    failures++;
                end
                if (got.last_of_triangle != exp_b.last_of_triangle) begin
                    $error("last_of_triangle exp %b got %b", exp_b.last_of_triangle,
                           got.last_of_triangle);
                    failures++;
                end
            end
        end
    end

    // Directed triangles: unit axes, flipped winding, extremes and degenerate cases.
    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h0001_0000;
        // Plain right triangle with positive determinant.
        send_corner(16'h0000, 0, 0, 0, 0, 0);
        send_corner(16'h0001, ONE, 0, 0, ONE, 0);
        send_corner(16'hFFFF, 0, ONE, 0, 0, ONE);
        // Negative determinant flips both vectors.
        send_corner(16'h1234, 0, 0, 0, 0, 0);
        send_corner(16'h8000, ONE, 0, 0, 0, ONE);
        send_corner(16'h7FFF, 0, ONE, 0, ONE, 0);
        // Zero determinant: identical texture coordinates.
        send_corner(16'h0002, 0, 0, 0, ONE, ONE);
        send_corner(16'h0003, ONE, 0, 0, ONE, ONE);
        send_corner(16'h0004, 0, ONE, 0, ONE, ONE);
        // Zero-length vectors: all positions equal.
        send_corner(16'h0005, ONE, ONE, ONE, 0, 0);
        send_corner(16'h0006, ONE, ONE, ONE, ONE, 0);
        send_corner(16'h0007, ONE, ONE, ONE, 0, ONE);
        // Field extremes: widest edges and UV deltas.
        send_corner(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000);
        send_corner(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000);
        send_corner(16'hAAAA, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF);
        // All ones and all zeros on every field, then alternating bit patterns.
        send_corner(16'h5555, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_corner(16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_corner(16'h0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'hAAAA_AAAA,
                    32'h5555_5555);
        wait_drained();
    endtask

    // Random triangles with random idling on both sides.
    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_corner($urandom, rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord());
    endtask

    // Receiver holds off while the sender keeps offering corners.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        fork
            begin
                repeat (HOLD_CY) @(posedge aclk);
                hold_receiver = 1'b0;
            end
            test_random(30);
        join
        wait_drained();
    endtask

    // No idling on either side for a stretch.
    task automatic test_no_idle();
        sender_idle_pct = 0;
        receiver_free = 1'b1;
        test_random(60);
        wait_drained();
        sender_idle_pct = 35;
        receiver_free = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150);
        wait_drained();
        test_backpressure();
        test_no_idle();
        test_random(162);
        wait_drained();
        if (failures == 0) $display("triangle_tangent_basis_tb: PASS");
        else $display("triangle_tangent_basis_tb: FAIL");
        $finish;
    end
endmodule
